FILE: rtl/core/rtac_pkg.sv
`default_nettype none
package rtac_pkg;

	localparam int VALUE_BITS = 16;
	localparam int CNT_W = $clog2(VALUE_BITS);
	localparam int RADIX_W = 6;
	localparam int CHAR_W = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [RADIX_W-1:0] DECIMAL_LIMIT = 6'd10;
	localparam logic [CHAR_W-1:0] DIGIT_ALPHA_OFFSET = 7'd7;
	localparam logic [CHAR_W-1:0] DIGIT_ZERO_CHAR = 7'd48;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		c = {1'b0, d} + DIGIT_ZERO_CHAR;
		if (d >= DECIMAL_LIMIT) begin
			c = c + DIGIT_ALPHA_OFFSET;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rtac_divider.sv
`default_nettype none
module rtac_divider (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                div_start,
	input  wire logic [rtac_pkg::VALUE_BITS-1:0]     dividend,
	input  wire logic [rtac_pkg::RADIX_W-1:0]        divisor,
	output logic                                     div_done,
	output logic [rtac_pkg::VALUE_BITS-1:0]          quotient,
	output logic [rtac_pkg::RADIX_W-1:0]             remainder
);

	// Restoring division, one quotient bit per cycle.

	logic                                running_q;
	logic                                done_q;
	logic [rtac_pkg::CNT_W-1:0]          cnt_q;
	logic [rtac_pkg::VALUE_BITS-1:0]     quo_q;
	logic [rtac_pkg::RADIX_W-1:0]        rem_q;
	logic [rtac_pkg::RADIX_W-1:0]        den_q;
	logic [rtac_pkg::RADIX_W:0]          trial;
	logic [rtac_pkg::RADIX_W:0]          diff;
	logic                                ge;

	assign trial = {rem_q, quo_q[rtac_pkg::VALUE_BITS-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (div_start) begin
				running_q <= 1'b1;
				cnt_q <= '0;
			end else if (running_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rtac_pkg::CNT_W'(rtac_pkg::VALUE_BITS - 1)) begin
					running_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (running_q) begin
			quo_q <= {quo_q[rtac_pkg::VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[rtac_pkg::RADIX_W-1:0] : trial[rtac_pkg::RADIX_W-1:0];
		end
	end

	assign div_done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

FILE: rtl/core/radix_to_ascii_converter.sv
// Each digit costs a load and one shift per dividend bit of the shared bit-serial
// divider, and then the digits are issued one strobe per cycle. One item is handled at
// a time; busy falls while the last digit is on the result ports. Results cannot be
// stalled: each digit is shown for one cycle.
// Reset: asynchronous, active low; radix returns to 10 and the block goes idle.
`default_nettype none
module radix_to_ascii_converter (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [rtac_pkg::VALUE_BITS-1:0]     value,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rtac_pkg::RADIX_W-1:0]        cfg_data,
	output logic                                     strobe,
	output logic [rtac_pkg::CHAR_W-1:0]              digit_char,
	output logic                                     last_digit
);

	rtac_pkg::state_t                    state_q;
	rtac_pkg::state_t                    state_nxt;
	logic [rtac_pkg::RADIX_W-1:0]        radix_q;
	logic [rtac_pkg::RADIX_W-1:0]        radix_eff;
	logic [rtac_pkg::CNT_W-1:0]          idx_q;
	logic [rtac_pkg::RADIX_W-1:0]        store_q [rtac_pkg::VALUE_BITS];
	logic                                strobe_q;
	logic                                last_q;
	logic [rtac_pkg::CHAR_W-1:0]         char_q;
	logic                                accept;
	logic                                div_start;
	logic                                div_done;
	logic [rtac_pkg::VALUE_BITS-1:0]     div_dividend;
	logic [rtac_pkg::VALUE_BITS-1:0]     div_quotient;
	logic [rtac_pkg::RADIX_W-1:0]        div_rem;
	logic                                more;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != rtac_pkg::ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		if (radix_q < rtac_pkg::RADIX_MIN) begin
			radix_eff = rtac_pkg::RADIX_MIN;
		end else if (radix_q > rtac_pkg::RADIX_MAX) begin
			radix_eff = rtac_pkg::RADIX_MAX;
		end else begin
			radix_eff = radix_q;
		end
	end

	assign more = (div_quotient != '0)
		&& (idx_q != rtac_pkg::CNT_W'(rtac_pkg::VALUE_BITS - 1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rtac_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = rtac_pkg::ST_DIVIDE;
				end
			end
			rtac_pkg::ST_DIVIDE: begin
				if (div_done && !more) begin
					state_nxt = rtac_pkg::ST_EMIT;
				end
			end
			rtac_pkg::ST_EMIT: begin
				if (idx_q == '0) begin
					state_nxt = rtac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = rtac_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_dividend = div_quotient;
		case (state_q)
			rtac_pkg::ST_IDLE: begin
				div_start = start;
				div_dividend = value;
			end
			rtac_pkg::ST_DIVIDE: begin
				div_start = div_done && more;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	rtac_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.div_start (div_start),
		.dividend  (div_dividend),
		.divisor   (radix_eff),
		.div_done  (div_done),
		.quotient  (div_quotient),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtac_pkg::ST_IDLE;
			radix_q <= rtac_pkg::RADIX_RESET;
			idx_q <= '0;
			strobe_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) begin
				radix_q <= cfg_data;
			end
			strobe_q <= (state_q == rtac_pkg::ST_EMIT);
			last_q <= (state_q == rtac_pkg::ST_EMIT) && (idx_q == '0);
			if (accept) begin
				idx_q <= '0;
			end else if (state_q == rtac_pkg::ST_DIVIDE && div_done && more) begin
				idx_q <= idx_q + 1'b1;
			end else if (state_q == rtac_pkg::ST_EMIT && idx_q != '0) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rtac_pkg::ST_DIVIDE && div_done) begin
			store_q[idx_q] <= div_rem;
		end
		if (state_q == rtac_pkg::ST_EMIT) begin
			char_q <= rtac_pkg::digit_to_char(store_q[idx_q]);
		end
	end

	assign strobe = strobe_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

	a_strobe_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == rtac_pkg::ST_EMIT))
		else $error("digit strobe without emit state");

	a_last_with_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_digit |-> strobe)
		else $error("last digit flag without strobe");

	a_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == rtac_pkg::ST_DIVIDE))
		else $error("divider finished outside divide state");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

endmodule
`default_nettype wire
